@@ hdl/bmpd_pkg.sv @@
package bmpd_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW    = $clog2(PAL_DEPTH);
   localparam int PAL_DW    = 24;

   localparam int Q_DEPTH = 3;

   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
   localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PALETTE,
      PH_PIXELS,
      PH_PADDING,
      PH_IDLE
   } phase_type;

   typedef enum logic [2:0] {
      STS_PIXEL     = 3'd0,
      STS_DONE      = 3'd1,
      STS_BAD_SIG   = 3'd2,
      STS_BAD_DEPTH = 3'd3,
      STS_BAD_SIZE  = 3'd4,
      STS_PAL_LARGE = 3'd5,
      STS_TRUNC     = 3'd6
   } status_type;

   // results caused by one file byte: an optional pixel, then an optional status
   typedef struct packed {
      logic        pix_vld;
      logic        sts_vld;
      status_type  sts;
      logic        use_pal;
      logic [11:0] x;
      logic [11:0] y;
      logic [31:0] argb;
   } bundle_type;

   function automatic logic [7:0] expand5(input logic [4:0] c);
      expand5 = {c, c[4:2]};
   endfunction

endpackage

@@ hdl/bmpd_ram.sv @@
module bmpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bmpd_parser.sv @@
module bmpd_parser #(
   parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [7:0]                    in_byte,
   input  logic                          in_last,
   input  logic [1:0]                    q_count,
   output logic                          s1_valid,
   output bmpd_pkg::bundle_type          s1_bundle,
   output logic                          ram_we,
   output logic [bmpd_pkg::PAL_AW-1:0]   ram_waddr,
   output logic [bmpd_pkg::PAL_DW-1:0]   ram_wdata,
   output logic [bmpd_pkg::PAL_AW-1:0]   ram_raddr
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int PPW = bmpd_pkg::PAL_AW + 2;

   localparam logic [5:0] OFS_WIDTH  = 6'd18;
   localparam logic [5:0] OFS_HEIGHT = 6'd22;
   localparam logic [5:0] OFS_DEPTH  = 6'd28;
   localparam logic [5:0] OFS_COLORS = 6'd46;
   localparam logic [5:0] HDR_LAST   = 6'd53;

   bmpd_pkg::phase_type phase_ff, phase_in;
   logic [5:0]     pos_ff, pos_in;
   logic [31:0]    wid_ff, wid_in;
   logic [31:0]    hgt_ff, hgt_in;
   logic [15:0]    dep_ff, dep_in;
   logic [31:0]    clr_ff, clr_in;
   logic [8:0]     ent_ff, ent_in;
   logic [PPW-1:0] ppos_ff, ppos_in;
   logic [23:0]    acc_ff, acc_in;
   logic [1:0]     bip_ff, bip_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [1:0]     pad_ff, pad_in;
   logic           s1_vld_ff;
   bmpd_pkg::bundle_type s1_ff, bnd;

   logic        accept;
   logic        eor;
   logic [2:0]  bpp;
   logic [31:0] pix_v;
   logic [1:0]  w_lane, h_lane, c_lane;
   logic        d_lane;
   logic        w_ok, h_ok;
   logic [1:0]  pad_calc;
   logic [3:0]  row_bytes_lo;

   assign in_ready = ({1'b0, q_count} + 3'(s1_vld_ff)) <= 3'd2;
   assign accept   = in_valid && in_ready;

   assign bpp    = dep_ff[5:3];
   assign w_lane = 2'(pos_ff - OFS_WIDTH);
   assign h_lane = 2'(pos_ff - OFS_HEIGHT);
   assign c_lane = 2'(pos_ff - OFS_COLORS);
   assign d_lane = 1'(pos_ff - OFS_DEPTH);
   assign w_ok   = (wid_ff != 32'd0) && (wid_ff <= 32'(MAX_WIDTH));
   assign h_ok   = (hgt_ff != 32'd0) && (hgt_ff <= 32'(MAX_HEIGHT));
   assign row_bytes_lo = wid_ff[1:0] * bpp[1:0];
   assign pad_calc = 2'(2'd0 - row_bytes_lo[1:0]);
   assign pix_v = {8'd0, acc_ff} | (32'(in_byte) << {bip_ff, 3'b000});

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      wid_in   = wid_ff;
      hgt_in   = hgt_ff;
      dep_in   = dep_ff;
      clr_in   = clr_ff;
      ent_in   = ent_ff;
      ppos_in  = ppos_ff;
      acc_in   = acc_ff;
      bip_in   = bip_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      pad_in   = pad_ff;
      bnd      = '0;
      eor      = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = ppos_ff[PPW-1:2];
      ram_wdata = {in_byte, acc_ff[15:8], acc_ff[7:0]};
      ram_raddr = '0;
      if (accept) begin
         case (phase_ff)
            bmpd_pkg::PH_HEADER: begin
               if (pos_ff == 6'd0) begin
                  acc_in = {16'd0, in_byte};
               end
               if (pos_ff inside {[OFS_WIDTH:OFS_WIDTH + 6'd3]}) begin
                  wid_in[{w_lane, 3'b000} +: 8] = in_byte;
               end
               if (pos_ff inside {[OFS_HEIGHT:OFS_HEIGHT + 6'd3]}) begin
                  hgt_in[{h_lane, 3'b000} +: 8] = in_byte;
               end
               if (pos_ff inside {[OFS_DEPTH:OFS_DEPTH + 6'd1]}) begin
                  dep_in[{d_lane, 3'b000} +: 8] = in_byte;
               end
               if (pos_ff inside {[OFS_COLORS:OFS_COLORS + 6'd3]}) begin
                  clr_in[{c_lane, 3'b000} +: 8] = in_byte;
               end
               if (pos_ff == 6'd1) begin
                  acc_in = '0;
                  if ({in_byte, acc_ff[7:0]} != bmpd_pkg::BMP_SIGNATURE) begin
                     bnd.sts_vld = 1'b1;
                     bnd.sts     = bmpd_pkg::STS_BAD_SIG;
                     phase_in    = bmpd_pkg::PH_IDLE;
                  end
               end
               if (phase_in == bmpd_pkg::PH_HEADER) begin
                  if (pos_ff >= HDR_LAST) begin
                     if (!(dep_ff inside {16'd8, 16'd16, 16'd24, 16'd32})) begin
                        bnd.sts_vld = 1'b1;
                        bnd.sts     = bmpd_pkg::STS_BAD_DEPTH;
                        phase_in    = bmpd_pkg::PH_IDLE;
                     end else if (!w_ok || !h_ok) begin
                        bnd.sts_vld = 1'b1;
                        bnd.sts     = bmpd_pkg::STS_BAD_SIZE;
                        phase_in    = bmpd_pkg::PH_IDLE;
                     end else if (dep_ff == 16'd8) begin
                        if (clr_ff > 32'(bmpd_pkg::PAL_DEPTH)) begin
                           bnd.sts_vld = 1'b1;
                           bnd.sts     = bmpd_pkg::STS_PAL_LARGE;
                           phase_in    = bmpd_pkg::PH_IDLE;
                        end else begin
                           ent_in   = (clr_ff == 32'd0) ? 9'(bmpd_pkg::PAL_DEPTH) : 9'(clr_ff);
                           ppos_in  = '0;
                           phase_in = bmpd_pkg::PH_PALETTE;
                        end
                     end else begin
                        phase_in = bmpd_pkg::PH_PIXELS;
                     end
                  end else begin
                     pos_in = pos_ff + 6'd1;
                  end
               end
            end
            bmpd_pkg::PH_PALETTE: begin
               case (ppos_ff[1:0])
                  2'd0: acc_in[7:0]  = in_byte;
                  2'd1: acc_in[15:8] = in_byte;
                  2'd2: begin
                     ram_we = 1'b1;
                     acc_in = '0;
                  end
                  default: ;
               endcase
               if ((11'(ppos_ff) + 11'd1) >= {2'b00, ent_ff} << 2) begin
                  phase_in = bmpd_pkg::PH_PIXELS;
               end else begin
                  ppos_in = ppos_ff + PPW'(1);
               end
            end
            bmpd_pkg::PH_PIXELS: begin
               if ((3'(bip_ff) + 3'd1) < bpp) begin
                  acc_in[{bip_ff, 3'b000} +: 8] = in_byte;
                  bip_in = bip_ff + 2'd1;
               end else begin
                  acc_in      = '0;
                  bip_in      = '0;
                  bnd.pix_vld = 1'b1;
                  bnd.sts     = bmpd_pkg::STS_PIXEL;
                  bnd.x       = 12'(col_ff);
                  bnd.y       = hgt_ff[11:0] - 12'd1 - 12'(row_ff);
                  case (bpp)
                     3'd4: bnd.argb = {(pix_v[31:24] == 8'd0) ? bmpd_pkg::ALPHA_OPAQUE
                                                              : pix_v[31:24], pix_v[23:0]};
                     3'd3: bnd.argb = {bmpd_pkg::ALPHA_OPAQUE, pix_v[23:0]};
                     3'd2: bnd.argb = {bmpd_pkg::ALPHA_OPAQUE,
                                       bmpd_pkg::expand5(pix_v[14:10]),
                                       bmpd_pkg::expand5(pix_v[9:5]),
                                       bmpd_pkg::expand5(pix_v[4:0])};
                     default: begin
                        bnd.use_pal = 1'b1;
                        ram_raddr   = (9'(in_byte) >= ent_ff) ? '0 : in_byte;
                     end
                  endcase
                  if ((32'(col_ff) + 32'd1) >= wid_ff) begin
                     pad_in = pad_calc;
                     if (pad_calc == 2'd0) begin
                        eor = 1'b1;
                     end else begin
                        phase_in = bmpd_pkg::PH_PADDING;
                     end
                  end else begin
                     col_in = col_ff + CW'(1);
                  end
               end
            end
            bmpd_pkg::PH_PADDING: begin
               if (pad_ff <= 2'd1) begin
                  pad_in = '0;
                  eor    = 1'b1;
               end else begin
                  pad_in = pad_ff - 2'd1;
               end
            end
            default: ;
         endcase
         if (eor) begin
            row_in = row_ff + RW'(1);
            col_in = '0;
            if ((32'(row_ff) + 32'd1) >= hgt_ff) begin
               bnd.sts_vld = 1'b1;
               bnd.sts     = bmpd_pkg::STS_DONE;
               phase_in    = bmpd_pkg::PH_IDLE;
            end else begin
               phase_in = bmpd_pkg::PH_PIXELS;
            end
         end
         if (in_last) begin
            if (phase_in != bmpd_pkg::PH_IDLE) begin
               bnd.sts_vld = 1'b1;
               bnd.sts     = bmpd_pkg::STS_TRUNC;
            end
            phase_in = bmpd_pkg::PH_HEADER;
            pos_in   = '0;
            wid_in   = '0;
            hgt_in   = '0;
            dep_in   = '0;
            clr_in   = '0;
            ent_in   = '0;
            ppos_in  = '0;
            acc_in   = '0;
            bip_in   = '0;
            col_in   = '0;
            row_in   = '0;
            pad_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bmpd_pkg::PH_HEADER;
         pos_ff    <= '0;
         wid_ff    <= '0;
         hgt_ff    <= '0;
         dep_ff    <= '0;
         clr_ff    <= '0;
         ent_ff    <= '0;
         ppos_ff   <= '0;
         acc_ff    <= '0;
         bip_ff    <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         pad_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         wid_ff    <= wid_in;
         hgt_ff    <= hgt_in;
         dep_ff    <= dep_in;
         clr_ff    <= clr_in;
         ent_ff    <= ent_in;
         ppos_ff   <= ppos_in;
         acc_ff    <= acc_in;
         bip_ff    <= bip_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
         s1_vld_ff <= accept && (bnd.pix_vld || bnd.sts_vld);
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= bnd;
   end

   assign s1_valid  = s1_vld_ff;
   assign s1_bundle = s1_ff;

endmodule

@@ hdl/bmpd_out_queue.sv @@
module bmpd_out_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  bmpd_pkg::bundle_type          in_bundle,
   input  logic [bmpd_pkg::PAL_DW-1:0]   pal_data,
   output logic [1:0]                    count,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [55:0]                   out_data,
   output logic [2:0]                    out_user,
   output logic                          out_last
);

   bmpd_pkg::bundle_type q_ff [bmpd_pkg::Q_DEPTH];
   bmpd_pkg::bundle_type q_in [bmpd_pkg::Q_DEPTH];
   bmpd_pkg::bundle_type head, push_bundle;
   logic [1:0] cnt_ff, cnt_in;
   logic       sent_ff, sent_in;
   logic       pix_word;
   logic       take;
   logic       pop;
   logic [1:0] widx;

   assign head      = q_ff[0];
   assign out_valid = cnt_ff != 2'd0;
   assign pix_word  = head.pix_vld && !sent_ff;
   assign out_user  = pix_word ? bmpd_pkg::STS_PIXEL : head.sts;
   assign out_data  = pix_word ? {head.argb, head.y, head.x} : 56'd0;
   assign out_last  = pix_word ? !head.sts_vld : 1'b1;
   assign take      = out_valid && out_ready;
   assign pop       = take && out_last;
   assign widx      = cnt_ff - 2'(pop);
   assign count     = cnt_ff;

   always_comb begin
      push_bundle = in_bundle;
      if (in_bundle.use_pal) begin
         push_bundle.argb = {bmpd_pkg::ALPHA_OPAQUE, pal_data};
      end
   end

   always_comb begin
      q_in = q_ff;
      if (pop) begin
         for (int i = 0; i < bmpd_pkg::Q_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      if (in_valid) begin
         q_in[widx] = push_bundle;
      end
      cnt_in  = cnt_ff - 2'(pop) + 2'(in_valid);
      sent_in = pop ? 1'b0 : (take ? 1'b1 : sent_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sent_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         sent_ff <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

@@ hdl/bmp_stream_decoder_core.sv @@
// BMP stream decoder.
// req_*: one file byte per word; req_tlast marks the last byte of a file, and
// the following byte starts the next file. Bytes flow at one per clock unless stalled.
// rsp_*: result words. rsp_tuser is the status (pixel, done or an error code);
// pixel words carry column, row (top row 0) and ARGB8888 color in rsp_tdata,
// status words carry zero data. rsp_tlast marks the final word caused by
// one input byte; a byte causes zero, one or two words.
// The parser stage registers each word together with the palette memory read,
// and the output queue registers it again before it appears on rsp.
// Throughput: one byte per cycle unless req_tready is low; a byte with a pixel and
// a status gives two output words. A three-entry output queue decouples the sides;
// req_tready drops once the queue and the lookup stage together hold three
// pending entries, so a stalled receiver backs up into the request side
// without losing words.
// Reset clears the parser and the queue; the palette memory keeps its
// contents and every file writes its palette before reading it.
module bmp_stream_decoder_core #(
   parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // file_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // pixel_x[11:0], pixel_y[23:12], pixel_argb[55:24]
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);

   logic                        s1_valid;
   bmpd_pkg::bundle_type        s1_bundle;
   logic [1:0]                  q_count;
   logic                        ram_we;
   logic [bmpd_pkg::PAL_AW-1:0] ram_waddr;
   logic [bmpd_pkg::PAL_DW-1:0] ram_wdata;
   logic [bmpd_pkg::PAL_AW-1:0] ram_raddr;
   logic [bmpd_pkg::PAL_DW-1:0] ram_rdata;

   bmpd_parser #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .q_count   (q_count),
      .s1_valid  (s1_valid),
      .s1_bundle (s1_bundle),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr)
   );

   bmpd_ram #(
      .WIDTH (bmpd_pkg::PAL_DW),
      .DEPTH (bmpd_pkg::PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bmpd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_bundle (s1_bundle),
      .pal_data  (ram_rdata),
      .count     (q_count),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_user  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule
